@@ src/i2cmw_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cmw_pkg
// Types, codes and constants for the three-byte I2C write sequencer.
// ----------------------------------------------------------------------------
package i2cmw_pkg;

    localparam int WAIT_WIDTH  = 16;
    localparam int SAMP_WIDTH  = 4;
    localparam logic [SAMP_WIDTH-1:0] ACK_SAMPLES = 4'd10;

    localparam int ADDR_WIDTH  = 7;
    localparam int BYTE_WIDTH  = 8;
    localparam int IN_WIDTH    = 24;
    localparam int OUT_WIDTH   = 8;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_ST_SDA     = 4'd1,
        PH_ST_SCL     = 4'd2,
        PH_ST_GAP     = 4'd3,
        PH_BIT_SET    = 4'd4,
        PH_BIT_HIGH   = 4'd5,
        PH_BIT_LOW    = 4'd6,
        PH_ACK_HIGH   = 4'd7,
        PH_ACK_SAMPLE = 4'd8,
        PH_GAP        = 4'd9,
        PH_SP_SDA     = 4'd10,
        PH_SP_SCL     = 4'd11,
        PH_SP_END     = 4'd12,
        PH_DONE       = 4'd13
    } t_phase;

    typedef enum logic {
        CFG_SLAVE_ADDR  = 1'b0,
        CFG_HALF_PERIOD = 1'b1
    } t_cfg_index;

    typedef enum logic {
        REQ_TICK  = 1'b0,
        REQ_START = 1'b1
    } t_req;

    localparam logic [1:0] BYTE_ADDR = 2'd0;
    localparam logic [1:0] BYTE_CTRL = 2'd1;
    localparam logic [1:0] BYTE_DATA = 2'd2;

    typedef struct packed {
        logic ack_ok;
        logic done_res;
        logic busy_res;
        logic sda_drive;
        logic sda_out;
        logic scl_out;
    } t_result;

    // hold length after a pin change; the changing tick counts as the first
    function automatic logic [WAIT_WIDTH-1:0] hold_ticks(input logic [15:0] half_period);
        logic [15:0] t;
        begin
            t = (half_period == 16'd0) ? 16'd0 : half_period - 16'd1;
            hold_ticks = WAIT_WIDTH'(t);
        end
    endfunction

endpackage

@@ src/i2c_master_three_byte_write.sv @@
// ----------------------------------------------------------------------------
// i2c_master_three_byte_write
// Pin-level I2C master for one write of address, control and data bytes.
// ----------------------------------------------------------------------------
// Every input beat is one time tick and yields one result beat holding the
// SCL, SDA and SDA-enable levels after that tick plus busy, done and ack
// status. A start beat (tuser high) while idle latches the control and data
// bytes; a start beat while busy counts as a plain tick. The sequencer state
// advances in the same cycle a beat is taken, so one beat per clock is
// accepted while the skid entry is empty; a two-entry output stage lets one
// more input beat be taken while the output side stalls. Register writes
// are taken every cycle and should be issued while idle.
module i2c_master_three_byte_write
    import i2cmw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // [7:0] data_byte, [15:8] control_byte, [16] sda_in, [23:17] zero
    input  logic [IN_WIDTH-1:0]  i_s_axis_tdata,
    // [0] req_type
    input  logic                 i_s_axis_tuser,

    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // [0] scl_out, [1] sda_out, [2] sda_drive, [3] busy_res, [4] done_res,
    // [5] ack_ok, [7:6] zero
    output logic [OUT_WIDTH-1:0] o_m_axis_tdata,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    logic [ADDR_WIDTH-1:0] r_slave_addr;
    logic [15:0]           r_half_period;

    t_phase                r_phase, n_phase;
    logic [WAIT_WIDTH-1:0] r_wait, n_wait;
    logic [2:0]            r_bit, n_bit;
    logic [1:0]            r_byte, n_byte;
    logic [BYTE_WIDTH-1:0] r_shift, n_shift;
    logic [BYTE_WIDTH-1:0] r_data, n_data;
    logic [BYTE_WIDTH-1:0] r_ctrl, n_ctrl;
    logic [SAMP_WIDTH-1:0] r_samp, n_samp;
    logic                  r_all_acked, n_all_acked;
    logic                  r_scl, n_scl;
    logic                  r_sda, n_sda;
    logic                  r_drv, n_drv;

    t_result               r_out, r_skid, n_res;
    logic                  r_out_valid, r_skid_valid;

    logic                  w_acc, w_take, w_start, w_sda_in;
    logic [1:0]            w_next_sel;
    logic [BYTE_WIDTH-1:0] w_next_byte;
    logic [SAMP_WIDTH-1:0] w_samp_inc;
    logic [WAIT_WIDTH-1:0] w_hold;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !r_skid_valid;
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign w_take          = r_out_valid && i_m_axis_tready;
    assign w_start         = (t_req'(i_s_axis_tuser) == REQ_START);
    assign w_sda_in        = i_s_axis_tdata[16];
    assign w_hold          = hold_ticks(r_half_period);
    assign w_samp_inc      = r_samp + SAMP_WIDTH'(1);
    assign w_next_sel      = (r_phase == PH_GAP) ? r_byte + 2'd1 : BYTE_ADDR;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out};

    always_comb begin
        case (w_next_sel)
            BYTE_ADDR: w_next_byte = {r_slave_addr, 1'b0};
            BYTE_CTRL: w_next_byte = r_ctrl;
            default:   w_next_byte = r_data;
        endcase
    end

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_wait      = r_wait;
        n_bit       = r_bit;
        n_byte      = r_byte;
        n_shift     = r_shift;
        n_data      = r_data;
        n_ctrl      = r_ctrl;
        n_samp      = r_samp;
        n_all_acked = r_all_acked;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_drv       = r_drv;
        if (r_phase == PH_IDLE) begin
            if (w_start) begin
                n_data      = i_s_axis_tdata[7:0];
                n_ctrl      = i_s_axis_tdata[15:8];
                n_all_acked = 1'b1;
                n_samp      = '0;
                n_byte      = BYTE_ADDR;
                n_scl       = 1'b1;
                n_sda       = 1'b1;
                n_drv       = 1'b1;
                n_wait      = w_hold;
                n_phase     = PH_ST_SDA;
            end
        end else if (r_wait != '0) begin
            n_wait = r_wait - WAIT_WIDTH'(1);
        end else begin
            case (r_phase)
                PH_ST_SDA: begin
                    n_sda   = 1'b0;
                    n_wait  = w_hold;
                    n_phase = PH_ST_SCL;
                end
                PH_ST_SCL: begin
                    n_scl   = 1'b0;
                    n_wait  = w_hold;
                    n_phase = PH_ST_GAP;
                end
                PH_ST_GAP: begin
                    n_wait  = w_hold;
                    n_byte  = BYTE_ADDR;
                    n_shift = w_next_byte;
                    n_bit   = 3'd7;
                    n_phase = PH_BIT_SET;
                end
                PH_BIT_SET: begin
                    n_sda   = r_shift[r_bit];
                    n_wait  = w_hold;
                    n_phase = PH_BIT_HIGH;
                end
                PH_BIT_HIGH: begin
                    n_scl   = 1'b1;
                    n_wait  = w_hold;
                    n_phase = PH_BIT_LOW;
                end
                PH_BIT_LOW: begin
                    n_scl  = 1'b0;
                    n_wait = w_hold;
                    if (r_bit == 3'd0) begin
                        n_drv   = 1'b0;
                        n_phase = PH_ACK_HIGH;
                    end else begin
                        n_bit   = r_bit - 3'd1;
                        n_sda   = r_shift[r_bit - 3'd1];
                        n_phase = PH_BIT_HIGH;
                    end
                end
                PH_ACK_HIGH: begin
                    n_scl   = 1'b1;
                    n_samp  = '0;
                    n_wait  = w_hold;
                    n_phase = PH_ACK_SAMPLE;
                end
                PH_ACK_SAMPLE: begin
                    if (!w_sda_in || w_samp_inc >= ACK_SAMPLES) begin
                        if (w_sda_in) begin
                            n_all_acked = 1'b0;
                        end
                        n_scl   = 1'b0;
                        n_drv   = 1'b1;
                        n_sda   = 1'b1;
                        n_samp  = '0;
                        n_wait  = w_hold;
                        n_phase = PH_GAP;
                    end else begin
                        n_samp = w_samp_inc;
                    end
                end
                PH_GAP: begin
                    n_wait = w_hold;
                    if (r_byte < BYTE_DATA) begin
                        n_byte  = r_byte + 2'd1;
                        n_shift = w_next_byte;
                        n_bit   = 3'd7;
                        n_phase = PH_BIT_SET;
                    end else begin
                        n_phase = PH_SP_SDA;
                    end
                end
                PH_SP_SDA: begin
                    n_sda   = 1'b0;
                    n_wait  = w_hold;
                    n_phase = PH_SP_SCL;
                end
                PH_SP_SCL: begin
                    n_scl   = 1'b1;
                    n_wait  = w_hold;
                    n_phase = PH_SP_END;
                end
                PH_SP_END: begin
                    n_sda   = 1'b1;
                    n_wait  = w_hold;
                    n_phase = PH_DONE;
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_wait  = '0;
                end
            endcase
        end
    end

    // result beat
    always_comb begin
        n_res.scl_out   = n_scl;
        n_res.sda_out   = n_sda;
        n_res.sda_drive = n_drv;
        n_res.busy_res  = (n_phase != PH_IDLE);
        n_res.done_res  = (r_phase == PH_DONE) && (r_wait == '0);
        n_res.ack_ok    = (r_phase == PH_DONE) && (r_wait == '0) && r_all_acked;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr  <= ADDR_WIDTH'(60);
            r_half_period <= 16'd50;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_SLAVE_ADDR:  r_slave_addr  <= i_cfg_data[ADDR_WIDTH-1:0];
                CFG_HALF_PERIOD: r_half_period <= i_cfg_data;
                default:         r_half_period <= r_half_period;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_wait      <= '0;
            r_bit       <= '0;
            r_byte      <= '0;
            r_shift     <= '0;
            r_samp      <= '0;
            r_all_acked <= 1'b1;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_drv       <= 1'b1;
        end else if (w_acc) begin
            r_phase     <= n_phase;
            r_wait      <= n_wait;
            r_bit       <= n_bit;
            r_byte      <= n_byte;
            r_shift     <= n_shift;
            r_samp      <= n_samp;
            r_all_acked <= n_all_acked;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
            r_drv       <= n_drv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_data <= n_data;
            r_ctrl <= n_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_acc;
            end
        end else if (w_acc) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end else if (w_acc) begin
            if (r_out_valid) begin
                r_skid <= n_res;
            end else begin
                r_out <= n_res;
            end
        end
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without an output beat");

    a_samp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_samp < ACK_SAMPLES)
        else $error("ack sample count past limit");

    a_release_in_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_drv |-> (r_phase == PH_ACK_HIGH || r_phase == PH_ACK_SAMPLE))
        else $error("SDA released outside an ack slot");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> !r_out.busy_res)
        else $error("done beat reports busy");

endmodule

@@ test/tb_i2c_master_three_byte_write.sv @@
// ----------------------------------------------------------------------------
// tb_i2c_master_three_byte_write
// Self-checking bench for the three-byte I2C write sequencer.
// ----------------------------------------------------------------------------
// Every tick beat sent in is mirrored in a pin-level sequencer model kept in a
// small scoreboard class. The model predicts the SCL/SDA/enable levels and the
// busy, done and ack flags for each beat, and every result beat is compared
// field by field in order. Directed transactions cover the reset address
// value, address and byte extremes, zero half period, full and missing
// acknowledges and starts issued while busy. Random transactions follow with
// random acknowledge behavior, under three source/sink stall patterns.
// ----------------------------------------------------------------------------
import i2cmw_pkg::*;

class pin_trace_board;
    logic [6:0]  target_addr;
    logic [15:0] half_ticks;
    t_phase      seq_phase;
    logic [15:0] hold_left;
    logic [2:0]  bit_pos;
    logic [1:0]  byte_sel;
    logic [7:0]  tx_byte;
    logic [7:0]  data_latch;
    logic [7:0]  ctrl_latch;
    logic [3:0]  ack_tries;
    logic        all_ack;
    logic        scl_lvl;
    logic        sda_lvl;
    logic        sda_en;
    t_result     pin_levels_q[$];
    int          errors;

    function new();
        target_addr = 7'd60;
        half_ticks  = 16'd50;
        seq_phase   = PH_IDLE;
        hold_left   = '0;
        bit_pos     = '0;
        byte_sel    = '0;
        tx_byte     = '0;
        data_latch  = '0;
        ctrl_latch  = '0;
        ack_tries   = '0;
        all_ack     = 1'b1;
        scl_lvl     = 1'b1;
        sda_lvl     = 1'b1;
        sda_en      = 1'b1;
        errors      = 0;
    endfunction

    function void set_reg(t_cfg_index idx, logic [15:0] val);
        case (idx)
            CFG_SLAVE_ADDR:  target_addr = val[6:0];
            CFG_HALF_PERIOD: half_ticks = val;
            default: ;
        endcase
    endfunction

    function logic [15:0] hold_len();
        return (half_ticks == 16'd0) ? 16'd0 : half_ticks - 16'd1;
    endfunction

    function void load_byte(logic [1:0] sel);
        byte_sel = sel;
        if (sel == BYTE_ADDR) begin
            tx_byte = {target_addr, 1'b0};
        end else if (sel == BYTE_CTRL) begin
            tx_byte = ctrl_latch;
        end else begin
            tx_byte = data_latch;
        end
        bit_pos   = 3'd7;
        seq_phase = PH_BIT_SET;
    endfunction

    function void note_tick(t_req req, logic [7:0] data, logic [7:0] ctrl, logic sda_in);
        t_result want;
        logic    done_now;
        logic    ack_now;
        done_now = 1'b0;
        ack_now  = 1'b0;
        if (seq_phase == PH_IDLE) begin
            if (req == REQ_START) begin
                data_latch = data;
                ctrl_latch = ctrl;
                all_ack    = 1'b1;
                ack_tries  = '0;
                byte_sel   = BYTE_ADDR;
                scl_lvl    = 1'b1;
                sda_lvl    = 1'b1;
                sda_en     = 1'b1;
                hold_left  = hold_len();
                seq_phase  = PH_ST_SDA;
            end
        end else if (hold_left != 16'd0) begin
            hold_left = hold_left - 16'd1;
        end else begin
            case (seq_phase)
                PH_ST_SDA: begin
                    sda_lvl   = 1'b0;
                    hold_left = hold_len();
                    seq_phase = PH_ST_SCL;
                end
                PH_ST_SCL: begin
                    scl_lvl   = 1'b0;
                    hold_left = hold_len();
                    seq_phase = PH_ST_GAP;
                end
                PH_ST_GAP: begin
                    hold_left = hold_len();
                    load_byte(BYTE_ADDR);
                end
                PH_BIT_SET: begin
                    sda_lvl   = tx_byte[bit_pos];
                    hold_left = hold_len();
                    seq_phase = PH_BIT_HIGH;
                end
                PH_BIT_HIGH: begin
                    scl_lvl   = 1'b1;
                    hold_left = hold_len();
                    seq_phase = PH_BIT_LOW;
                end
                PH_BIT_LOW: begin
                    scl_lvl = 1'b0;
                    if (bit_pos == 3'd0) begin
                        sda_en    = 1'b0;
                        seq_phase = PH_ACK_HIGH;
                    end else begin
                        bit_pos   = bit_pos - 3'd1;
                        sda_lvl   = tx_byte[bit_pos];
                        seq_phase = PH_BIT_HIGH;
                    end
                    hold_left = hold_len();
                end
                PH_ACK_HIGH: begin
                    scl_lvl   = 1'b1;
                    ack_tries = '0;
                    hold_left = hold_len();
                    seq_phase = PH_ACK_SAMPLE;
                end
                PH_ACK_SAMPLE: begin
                    if (sda_in == 1'b0) begin
                        done_now = 1'b1;
                    end else begin
                        ack_tries = ack_tries + 4'd1;
                        if (ack_tries >= ACK_SAMPLES) begin
                            all_ack  = 1'b0;
                            done_now = 1'b1;
                        end
                    end
                    if (done_now) begin
                        scl_lvl   = 1'b0;
                        sda_en    = 1'b1;
                        sda_lvl   = 1'b1;
                        ack_tries = '0;
                        hold_left = hold_len();
                        seq_phase = PH_GAP;
                    end
                    done_now = 1'b0;
                end
                PH_GAP: begin
                    hold_left = hold_len();
                    if (byte_sel < BYTE_DATA) begin
                        load_byte(byte_sel + 2'd1);
                    end else begin
                        seq_phase = PH_SP_SDA;
                    end
                end
                PH_SP_SDA: begin
                    sda_lvl   = 1'b0;
                    hold_left = hold_len();
                    seq_phase = PH_SP_SCL;
                end
                PH_SP_SCL: begin
                    scl_lvl   = 1'b1;
                    hold_left = hold_len();
                    seq_phase = PH_SP_END;
                end
                PH_SP_END: begin
                    sda_lvl   = 1'b1;
                    hold_left = hold_len();
                    seq_phase = PH_DONE;
                end
                default: begin
                    done_now  = 1'b1;
                    ack_now   = all_ack;
                    seq_phase = PH_IDLE;
                    hold_left = '0;
                end
            endcase
        end
        want.scl_out   = scl_lvl;
        want.sda_out   = sda_lvl;
        want.sda_drive = sda_en;
        want.busy_res  = (seq_phase != PH_IDLE);
        want.done_res  = done_now;
        want.ack_ok    = ack_now;
        pin_levels_q.push_back(want);
    endfunction

    function void match_bit(string name, logic want, logic got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function void check_beat(logic [7:0] beat);
        t_result got;
        t_result want;
        if (pin_levels_q.size() == 0) begin
            $error("result beat %h with nothing expected", beat);
            errors++;
            return;
        end
        got  = beat[5:0];
        want = pin_levels_q.pop_front();
        match_bit("scl_out", want.scl_out, got.scl_out);
        match_bit("sda_out", want.sda_out, got.sda_out);
        match_bit("sda_drive", want.sda_drive, got.sda_drive);
        match_bit("busy_res", want.busy_res, got.busy_res);
        match_bit("done_res", want.done_res, got.done_res);
        match_bit("ack_ok", want.ack_ok, got.ack_ok);
    endfunction

    function int pending();
        return pin_levels_q.size();
    endfunction
endclass

module tb_i2c_master_three_byte_write;

    localparam int CYCLE_LIMIT = 500_000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [IN_WIDTH-1:0]  i_s_axis_tdata = '0;
    logic                 i_s_axis_tuser = 1'b0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [OUT_WIDTH-1:0] o_m_axis_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    t_cfg_index           i_cfg_index = CFG_SLAVE_ADDR;
    logic [15:0]          i_cfg_data = '0;

    pin_trace_board sb;
    int             src_idle_pct = 0;
    int             sink_idle_pct = 0;
    int             ack_pct = 100;
    int             cycle_cnt = 0;

    i2c_master_three_byte_write dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_i2c_master_three_byte_write: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_beat(o_m_axis_tdata);
        end
    end

    task automatic send_item(t_req req, logic [7:0] data, logic [7:0] ctrl, logic sda);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= req;
        i_s_axis_tdata  <= {7'd0, sda, ctrl, data};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_tick(req, data, ctrl, sda);
    endtask

    function automatic int pick_ack_pct();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return 10;
            2:       return 30;
            3:       return 70;
            default: return 100;
        endcase
    endfunction

    task automatic send_next();
        t_req       req;
        logic [7:0] data;
        logic [7:0] ctrl;
        logic       sda;
        req  = REQ_TICK;
        data = 8'($urandom);
        ctrl = 8'($urandom);
        sda  = 1'($urandom_range(0, 1));
        if (sb.seq_phase == PH_IDLE) begin
            if ($urandom_range(0, 99) < 60) begin
                req     = REQ_START;
                ack_pct = pick_ack_pct();
            end
        end else begin
            if ($urandom_range(0, 99) < 3) req = REQ_START;
            if (sb.seq_phase == PH_ACK_SAMPLE && sb.hold_left == 16'd0) begin
                sda = ($urandom_range(0, 99) < ack_pct) ? 1'b0 : 1'b1;
            end
        end
        send_item(req, data, ctrl, sda);
    endtask

    // hold the source until every expected beat is back
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic finish_transaction();
        while (sb.seq_phase != PH_IDLE) send_next();
        drain_results();
    endtask

    task automatic write_reg(t_cfg_index idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_transaction(logic [7:0] data, logic [7:0] ctrl, int pct, bit busy_start);
        ack_pct = pct;
        send_item(REQ_START, data, ctrl, 1'($urandom_range(0, 1)));
        if (busy_start) send_item(REQ_START, ~data, ~ctrl, 1'b1);
        finish_transaction();
    endtask

    task automatic random_phase(int count, logic [15:0] half);
        write_reg(CFG_SLAVE_ADDR, 16'($urandom_range(0, 65535)));
        write_reg(CFG_HALF_PERIOD, half);
        repeat (count) send_next();
        finish_transaction();
    endtask

    initial begin
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct  = 15;
        sink_idle_pct = 71;
        write_reg(CFG_HALF_PERIOD, 16'd3);
        run_transaction(8'h3C, 8'hC3, 100, 1'b0);
        write_reg(CFG_SLAVE_ADDR, 16'h007F);
        write_reg(CFG_HALF_PERIOD, 16'd0);
        run_transaction(8'hFF, 8'h00, 100, 1'b1);
        run_transaction(8'h00, 8'hFF, 0, 1'b0);
        write_reg(CFG_SLAVE_ADDR, 16'h0000);
        run_transaction(8'hA5, 8'h5A, 30, 1'b0);
        run_transaction(8'h5A, 8'hA5, 70, 1'b1);
        write_reg(CFG_HALF_PERIOD, 16'hFFFF);
        repeat (8) begin
            send_item(REQ_TICK, 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
        end
        drain_results();

        random_phase(150, 16'd1);

        src_idle_pct  = 71;
        sink_idle_pct = 15;
        random_phase(150, 16'd2);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        random_phase(100, 16'd1);
        random_phase(100, 16'd3);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_i2c_master_three_byte_write: PASS");
        end else begin
            $display("tb_i2c_master_three_byte_write: FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/i2cmw_pkg.sv
src/i2c_master_three_byte_write.sv
test/tb_i2c_master_three_byte_write.sv
